### rtl/tcc_pkg.sv
// Package: widths, status codes and shared types for the circumcenter unit
`timescale 1ns / 1ps
`default_nettype none
package tcc_pkg;
	localparam int CW = 32;
	localparam int DW = 2 * CW + 4;
	localparam int NW = 3 * CW + 4;
	localparam int QW = NW - DW + 2;
	localparam int NSTEP = 2;
	localparam int NSTG = (QW + NSTEP - 1) / NSTEP;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DEGEN = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [NW-1:0] num;
		logic [DW-1:0] den;
		logic [QW-1:0] quo;
		logic neg;
		logic big;
	} div_lane_t;
endpackage
`default_nettype wire

### rtl/tcc_front.sv
// Front end: differences, determinant and numerators over four registered stages
`timescale 1ns / 1ps
`default_nettype none
module tcc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire logic signed [tcc_pkg::CW-1:0] ax, ay, bx, by, cx, cy,
	output logic out_valid,
	output logic signed [tcc_pkg::NW-1:0] nx,
	output logic signed [tcc_pkg::NW-1:0] ny,
	output logic signed [tcc_pkg::DW-1:0] den
);
	localparam int W1 = tcc_pkg::CW + 1;
	localparam int W2 = 2 * tcc_pkg::CW + 2;
	logic [3:0] v_q;
	logic signed [tcc_pkg::CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [W1-1:0] dybc_s1, dyca_s1, dyab_s1, dxcb_s1, dxac_s1, dxba_s1;
	logic signed [W2-1:0] sa_s2, sb_s2, sc_s2, p0_s2, p1_s2, p2_s2;
	logic signed [W1-1:0] dybc_s2, dyca_s2, dyab_s2, dxcb_s2, dxac_s2, dxba_s2;
	logic signed [W1-1:0] ah, al, bh, bl, ch, cl;
	logic signed [W2-1:0] xh0_s3, xl0_s3, xh1_s3, xl1_s3, xh2_s3, xl2_s3;
	logic signed [W2-1:0] yh0_s3, yl0_s3, yh1_s3, yl1_s3, yh2_s3, yl2_s3;
	logic signed [tcc_pkg::DW-1:0] d_s3;

	// split each squared norm into two unsigned halves
	assign ah = {1'b0, sa_s2[2*tcc_pkg::CW-1:tcc_pkg::CW]};
	assign al = {1'b0, sa_s2[tcc_pkg::CW-1:0]};
	assign bh = {1'b0, sb_s2[2*tcc_pkg::CW-1:tcc_pkg::CW]};
	assign bl = {1'b0, sb_s2[tcc_pkg::CW-1:0]};
	assign ch = {1'b0, sc_s2[2*tcc_pkg::CW-1:tcc_pkg::CW]};
	assign cl = {1'b0, sc_s2[tcc_pkg::CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= ax; ay_s1 <= ay; bx_s1 <= bx;
			by_s1 <= by; cx_s1 <= cx; cy_s1 <= cy;
			dybc_s1 <= W1'(by) - W1'(cy);
			dyca_s1 <= W1'(cy) - W1'(ay);
			dyab_s1 <= W1'(ay) - W1'(by);
			dxcb_s1 <= W1'(cx) - W1'(bx);
			dxac_s1 <= W1'(ax) - W1'(cx);
			dxba_s1 <= W1'(bx) - W1'(ax);
			sa_s2 <= W2'(ax_s1) * W2'(ax_s1) + W2'(ay_s1) * W2'(ay_s1);
			sb_s2 <= W2'(bx_s1) * W2'(bx_s1) + W2'(by_s1) * W2'(by_s1);
			sc_s2 <= W2'(cx_s1) * W2'(cx_s1) + W2'(cy_s1) * W2'(cy_s1);
			p0_s2 <= W2'(ax_s1) * W2'(dybc_s1);
			p1_s2 <= W2'(bx_s1) * W2'(dyca_s1);
			p2_s2 <= W2'(cx_s1) * W2'(dyab_s1);
			dybc_s2 <= dybc_s1; dyca_s2 <= dyca_s1; dyab_s2 <= dyab_s1;
			dxcb_s2 <= dxcb_s1; dxac_s2 <= dxac_s1; dxba_s2 <= dxba_s1;
			xh0_s3 <= W2'(ah) * W2'(dybc_s2);
			xl0_s3 <= W2'(al) * W2'(dybc_s2);
			xh1_s3 <= W2'(bh) * W2'(dyca_s2);
			xl1_s3 <= W2'(bl) * W2'(dyca_s2);
			xh2_s3 <= W2'(ch) * W2'(dyab_s2);
			xl2_s3 <= W2'(cl) * W2'(dyab_s2);
			yh0_s3 <= W2'(ah) * W2'(dxcb_s2);
			yl0_s3 <= W2'(al) * W2'(dxcb_s2);
			yh1_s3 <= W2'(bh) * W2'(dxac_s2);
			yl1_s3 <= W2'(bl) * W2'(dxac_s2);
			yh2_s3 <= W2'(ch) * W2'(dxba_s2);
			yl2_s3 <= W2'(cl) * W2'(dxba_s2);
			d_s3 <= (tcc_pkg::DW'(p0_s2) + tcc_pkg::DW'(p1_s2) + tcc_pkg::DW'(p2_s2)) <<< 1;
			nx <= (tcc_pkg::NW'(xh0_s3) <<< tcc_pkg::CW) + tcc_pkg::NW'(xl0_s3)
				+ (tcc_pkg::NW'(xh1_s3) <<< tcc_pkg::CW) + tcc_pkg::NW'(xl1_s3)
				+ (tcc_pkg::NW'(xh2_s3) <<< tcc_pkg::CW) + tcc_pkg::NW'(xl2_s3);
			ny <= (tcc_pkg::NW'(yh0_s3) <<< tcc_pkg::CW) + tcc_pkg::NW'(yl0_s3)
				+ (tcc_pkg::NW'(yh1_s3) <<< tcc_pkg::CW) + tcc_pkg::NW'(yl1_s3)
				+ (tcc_pkg::NW'(yh2_s3) <<< tcc_pkg::CW) + tcc_pkg::NW'(yl2_s3);
			den <= d_s3;
		end
	end

	assign out_valid = v_q[3];
endmodule
`default_nettype wire

### rtl/tcc_div.sv
// Pipelined restoring divider with round half away from zero and saturation
`timescale 1ns / 1ps
`default_nettype none
module tcc_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire logic signed [tcc_pkg::NW-1:0] num,
	input wire logic signed [tcc_pkg::DW-1:0] den,
	output logic out_valid,
	output logic signed [tcc_pkg::CW-1:0] quo,
	output logic sat
);
	localparam int NW = tcc_pkg::NW;
	localparam int QW = tcc_pkg::QW;
	localparam int NS = tcc_pkg::NSTG;
	tcc_pkg::div_lane_t ln_s [0:NS];
	tcc_pkg::div_lane_t nxt [0:NS-1];
	logic [NS+1:0] v_q;
	logic [tcc_pkg::DW-1:0] md;
	logic [NW-1:0] mn;
	logic [QW-1:0] q_r;
	logic [NW-1:0] r2;
	logic [QW:0] q_inc;
	logic [QW:0] lim;
	logic ovf;

	assign mn = num[NW-1] ? NW'(-num) : NW'(num);
	assign md = den[tcc_pkg::DW-1] ? -den : den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS:0], in_valid};
	end

	always_comb begin
		logic [NW:0] t;
		t = '0;
		for (int g = 0; g < NS; g++) begin
			nxt[g] = ln_s[g];
			for (int k = 0; k < tcc_pkg::NSTEP; k++) begin
				if (g * tcc_pkg::NSTEP + k < QW) begin
					t = {nxt[g].rem, nxt[g].num[NW-1]};
					nxt[g].num = nxt[g].num << 1;
					nxt[g].quo = {nxt[g].quo[QW-2:0], 1'b0};
					if (t >= (NW+1)'(nxt[g].den)) begin
						t = t - (NW+1)'(nxt[g].den);
						nxt[g].quo[0] = 1'b1;
					end
					nxt[g].rem = t[NW-1:0];
				end
			end
		end
	end

	// quotient fits QW bits only when the high part of the numerator is below the divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			ln_s[0].rem <= mn >> QW;
			ln_s[0].num <= mn << (NW - QW);
			ln_s[0].den <= md;
			ln_s[0].quo <= '0;
			ln_s[0].neg <= num[NW-1] ^ den[tcc_pkg::DW-1];
			ln_s[0].big <= (mn >> QW) >= NW'(md);
			for (int g = 0; g < NS; g++) ln_s[g + 1] <= nxt[g];
		end
	end

	assign r2 = ln_s[NS].rem << 1;
	assign q_r = ln_s[NS].quo;
	assign q_inc = {1'b0, q_r} + ((QW+1)'((r2 >= NW'(ln_s[NS].den)) ? 1 : 0));
	assign lim = ln_s[NS].neg ? (QW+1)'(1) << (tcc_pkg::CW - 1)
		: ((QW+1)'(1) << (tcc_pkg::CW - 1)) - (QW+1)'(1);
	assign ovf = ln_s[NS].big || (q_inc > lim);

	always_ff @(posedge clk) begin
		if (adv) begin
			sat <= ovf;
			if (ln_s[NS].neg) quo <= -(ovf ? lim[tcc_pkg::CW-1:0] : q_inc[tcc_pkg::CW-1:0]);
			else quo <= ovf ? lim[tcc_pkg::CW-1:0] : q_inc[tcc_pkg::CW-1:0];
		end
	end

	assign out_valid = v_q[NS+1];
endmodule
`default_nettype wire

### rtl/triangle_circumcenter_unit.sv
// Top level: circumcenter of one Q16.16 triangle per cycle
// Pipeline: 4 front-end stages plus NSTG+2 divider stages.
// Throughput: one triangle per cycle; the whole pipeline advances unless a valid output is stalled.
// The output register holds a result while stall is high; an input is taken when not stalled.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module triangle_circumcenter_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [tcc_pkg::CW-1:0] vertex_a_x, vertex_a_y,
	input wire logic signed [tcc_pkg::CW-1:0] vertex_b_x, vertex_b_y,
	input wire logic signed [tcc_pkg::CW-1:0] vertex_c_x, vertex_c_y,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [tcc_pkg::CW-1:0] center_x,
	output logic signed [tcc_pkg::CW-1:0] center_y,
	output logic [1:0] result_status
);
	logic adv, fv, xv, yv, zero_s;
	logic signed [tcc_pkg::NW-1:0] nx, ny;
	logic signed [tcc_pkg::DW-1:0] den;
	logic signed [tcc_pkg::CW-1:0] qx, qy;
	logic sx, sy;
	logic [tcc_pkg::NSTG+1:0] z_q;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	tcc_front u_front (.clk, .arst_n, .adv, .in_valid,
		.ax(vertex_a_x), .ay(vertex_a_y), .bx(vertex_b_x), .by(vertex_b_y),
		.cx(vertex_c_x), .cy(vertex_c_y), .out_valid(fv), .nx, .ny, .den);

	assign zero_s = den == '0;

	tcc_div u_dx (.clk, .arst_n, .adv, .in_valid(fv), .num(nx),
		.den(zero_s ? tcc_pkg::DW'(1) : den), .out_valid(xv), .quo(qx), .sat(sx));
	tcc_div u_dy (.clk, .arst_n, .adv, .in_valid(fv), .num(ny),
		.den(zero_s ? tcc_pkg::DW'(1) : den), .out_valid(yv), .quo(qy), .sat(sy));

	always_ff @(posedge clk) begin
		if (adv) z_q <= {z_q[tcc_pkg::NSTG:0], zero_s};
	end

	always_comb begin
		out_valid = xv;
		if (z_q[tcc_pkg::NSTG+1]) begin
			center_x = '0;
			center_y = '0;
			result_status = tcc_pkg::ST_DEGEN;
		end else begin
			center_x = qx;
			center_y = qy;
			result_status = (sx || sy) ? tcc_pkg::ST_SAT : tcc_pkg::ST_OK;
		end
	end

`ifndef SYNTH
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n) xv == yv)
		else $error("divider lanes out of step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(center_x))
		else $error("stalled result changed");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status == tcc_pkg::ST_DEGEN |-> center_x == '0 && center_y == '0)
		else $error("degenerate result not zero");
`endif
endmodule
`default_nettype wire

### dv/triangle_circumcenter_unit_tb.sv
// Testbench for the circumcenter unit: queued driver, stalling monitor, exact-arithmetic predictor
`timescale 1ns / 1ps
module triangle_circumcenter_unit_tb;
	localparam int WW = 208;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 40;

	typedef logic signed [WW-1:0] wide_t;
	typedef logic signed [tcc_pkg::CW-1:0] coord_t;

	typedef struct {
		coord_t ax, ay, bx, by, cx, cy;
		bit drain;
	} triangle_t;

	typedef struct {
		coord_t x, y;
		tcc_pkg::status_t status;
	} center_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	coord_t vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y;
	logic out_valid, out_stall;
	coord_t center_x, center_y;
	logic [1:0] result_status;

	triangle_t pending_tris[$];
	center_t expected_centers[$];
	int errors = 0;
	int sent = 0, received = 0, idle_cycles = 0;
	int n_degen = 0, n_sat = 0, n_ok = 0;
	int in_gap = 0, out_gap = 0;
	bit stim_done = 0;

	triangle_circumcenter_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.center_x(center_x), .center_y(center_y), .result_status(result_status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic coord_t round_quotient(wide_t n, wide_t d, inout bit sat);
		bit neg;
		wide_t mn, md, q, r, lim;
		neg = n[WW-1] ^ d[WW-1];
		mn = n[WW-1] ? -n : n;
		md = d[WW-1] ? -d : d;
		q = mn / md;
		r = mn - q * md;
		if (2 * r >= md) q = q + 1;
		lim = (wide_t'(1) <<< (tcc_pkg::CW - 1)) - (neg ? 0 : 1);
		if (q > lim) begin
			sat = 1;
			q = lim;
		end
		if (neg) q = -q;
		return q[tcc_pkg::CW-1:0];
	endfunction

	function automatic center_t circumcenter(triangle_t t);
		wide_t ax, ay, bx, by, cx, cy, den, sa, sb, sc, nx, ny;
		bit sat;
		center_t c;
		ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
		sat = 0;
		den = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
		if (den == 0) begin
			c.x = '0;
			c.y = '0;
			c.status = tcc_pkg::ST_DEGEN;
			return c;
		end
		sa = ax * ax + ay * ay;
		sb = bx * bx + by * by;
		sc = cx * cx + cy * cy;
		nx = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
		ny = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
		c.x = round_quotient(nx, den, sat);
		c.y = round_quotient(ny, den, sat);
		c.status = sat ? tcc_pkg::ST_SAT : tcc_pkg::ST_OK;
		return c;
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit calm_phase();
		return ((sent / 150) % 4) == 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		triangle_t t;
		bit busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			{vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y} <= '0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				t.ax = vertex_a_x; t.ay = vertex_a_y; t.bx = vertex_b_x;
				t.by = vertex_b_y; t.cx = vertex_c_x; t.cy = vertex_c_y;
				expected_centers.push_back(circumcenter(t));
				sent++;
				busy = 0;
				in_gap = calm_phase() ? 0 : random_gap();
			end
			if (!busy) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_tris.size() > 0 &&
						!(pending_tris[0].drain && expected_centers.size() > 0)) begin
					t = pending_tris.pop_front();
					in_valid <= 1'b1;
					vertex_a_x <= t.ax; vertex_a_y <= t.ay;
					vertex_b_x <= t.bx; vertex_b_y <= t.by;
					vertex_c_x <= t.cx; vertex_c_y <= t.cy;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		center_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				received++;
				if (expected_centers.size() == 0) begin
					$error("result with nothing expected: x=%0d y=%0d status=%0d",
						center_x, center_y, result_status);
					errors++;
				end else begin
					e = expected_centers.pop_front();
					if (center_x !== e.x) begin
						$error("center_x expected %0d got %0d", e.x, center_x);
						errors++;
					end
					if (center_y !== e.y) begin
						$error("center_y expected %0d got %0d", e.y, center_y);
						errors++;
					end
					if (result_status !== e.status) begin
						$error("result_status expected %0d got %0d", e.status, result_status);
						errors++;
					end
					case (e.status)
						tcc_pkg::ST_DEGEN: n_degen++;
						tcc_pkg::ST_SAT: n_sat++;
						default: n_ok++;
					endcase
				end
			end
			if (calm_phase()) begin
				out_stall <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_gap = random_gap();
				out_stall <= out_gap > 0;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic add_tri(coord_t ax, coord_t ay, coord_t bx, coord_t by, coord_t cx,
			coord_t cy, bit drain = 0);
		triangle_t t;
		t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.cx = cx; t.cy = cy;
		t.drain = drain;
		pending_tris.push_back(t);
	endtask

	function automatic coord_t rand_coord(int bits);
		coord_t v;
		v = $urandom;
		if (bits < tcc_pkg::CW) v = v >>> (tcc_pkg::CW - bits);
		return v;
	endfunction

	task automatic add_random(bit drain);
		int kind, bits, k1, k2;
		coord_t ax, ay, dx, dy;
		kind = $urandom_range(0, 99);
		bits = (kind < 45) ? $urandom_range(4, 20) : (kind < 65) ? tcc_pkg::CW
			: $urandom_range(20, 31);
		if (kind >= 80 && kind < 92) begin
			ax = rand_coord(24); ay = rand_coord(24);
			dx = rand_coord(14); dy = rand_coord(14);
			k1 = $urandom_range(0, 200) - 100;
			k2 = $urandom_range(0, 200) - 100;
			add_tri(ax, ay, ax + k1 * dx, ay + k1 * dy, ax + k2 * dx, ay + k2 * dy, drain);
		end else if (kind >= 92) begin
			ax = rand_coord(bits); ay = rand_coord(bits);
			dx = rand_coord(6); dy = rand_coord(6);
			add_tri(ax, ay, ax + dx, ay + dy, ax + dy, ay - dx + 1, drain);
		end else begin
			add_tri(rand_coord(bits), rand_coord(bits), rand_coord(bits), rand_coord(bits),
				rand_coord(bits), rand_coord(bits), drain);
		end
	endtask

	initial begin
		coord_t mx, mn;
		mx = {1'b0, {(tcc_pkg::CW-1){1'b1}}};
		mn = {1'b1, {(tcc_pkg::CW-1){1'b0}}};
		arst_n = 1'b0;
		add_tri(0, 0, 0, 0, 0, 0);
		add_tri(65536, 65536, 65536, 65536, 65536, 65536);
		add_tri(0, 0, 65536, 65536, 131072, 131072);
		add_tri(0, 0, 131072, 0, 0, 131072);
		add_tri(0, 0, 65536, 0, 0, 65536);
		add_tri(0, 0, 1, 0, 0, 1);
		add_tri(0, 0, 3, 0, 0, 1);
		add_tri(-65536, 0, 65536, 0, 0, 65536);
		add_tri(mx, mx, mn, mn, mx, mn);
		add_tri(mn, mn, mx, mn, mn, mx);
		add_tri(mx, 0, mn, 0, 0, mx);
		add_tri(mn, mx, mx, mx, 0, mn);
		add_tri(0, 0, 1, 0, mx, 1);
		add_tri(0, 0, -1, 0, mn, -1);
		add_tri(0, 0, 1, 1, 2, 1);
		add_tri(-1, -1, -1, -1, -1, -1);
		add_tri(mx, mx, mx, mx, mx, mx);
		add_tri(0, 0, 2, 0, 1, 1);
		add_tri(100, -200, -300, 400, 500, 600);
		add_tri(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'h0f0f0f0f, 32'hf0f0f0f0);
		for (int i = 0; i < 1130; i++) add_random(i == 500);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_tris.size() == 0);
		@(posedge clk);
		while (in_valid || expected_centers.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d triangles: %0d regular, %0d degenerate, %0d saturated",
			sent, n_ok, n_degen, n_sat);
		$display("%0d results checked with random stalls on both sides", received);
		if (errors == 0 && expected_centers.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
